/* hw/rtl/heightfield_triangle_sampler_assert.svh */
`ifndef HEIGHTFIELD_TRIANGLE_SAMPLER_ASSERT_SVH
`define HEIGHTFIELD_TRIANGLE_SAMPLER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and held off during reset.
`define HTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and held off during reset.
`define HTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/hts_pkg.sv */
package hts_pkg;

    localparam int DEF_MAX_SIDE         = 256;
    localparam int DEF_HEIGHT_FRAC_BITS = 8;

    localparam int OP_W      = 3;
    localparam int CELL_W    = 16;
    localparam int H_W       = 24;
    localparam int SIZE_W    = 9;
    localparam int INV_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 24;

    localparam logic [OP_W-1:0] OP_WR_FIN  = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_BASE = 3'd1;
    localparam logic [OP_W-1:0] OP_RESTORE = 3'd2;
    localparam logic [OP_W-1:0] OP_RD_FIN  = 3'd3;
    localparam logic [OP_W-1:0] OP_RD_BASE = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTSIDE = 2'd3;

    localparam logic [SIZE_W-1:0] RST_SIZE    = 9'd2;
    localparam logic [INV_W-1:0]  RST_INV     = 24'd65536;
    localparam logic [H_W-1:0]    RST_OUTSIDE = 24'hFC1800;
    localparam logic [SIZE_W-1:0] MIN_SIZE    = 9'd2;

    localparam logic signed [H_W-1:0] H_MAX = 24'sh7FFFFF;
    localparam logic signed [H_W-1:0] H_MIN = 24'sh800000;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic signed [CELL_W-1:0] cell_x;
        logic signed [CELL_W-1:0] cell_z;
        logic signed [H_W-1:0]    height_value;
        logic signed [H_W-1:0]    pos_x;
        logic signed [H_W-1:0]    pos_z;
    } t_in_item;

    typedef struct packed {
        logic signed [H_W-1:0] height_out;
        logic                  inside_res;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_RESTORE,
        S_MUL_Z,
        S_ADD_Z,
        S_CHECK,
        S_RD00,
        S_RD10,
        S_RD01,
        S_RD11,
        S_CAP11,
        S_DIFF,
        S_PROD_A,
        S_PROD_B,
        S_SUM,
        S_FINISH
    } t_state;

    typedef enum logic {
        ADDR_CELL,
        ADDR_NBR
    } t_addr_sel;

    typedef enum logic [1:0] {
        NBR_00,
        NBR_10,
        NBR_01,
        NBR_11
    } t_nbr;

    typedef enum logic [1:0] {
        MUL_PX,
        MUL_PZ,
        MUL_TA,
        MUL_TB
    } t_mul_sel;

    typedef struct packed {
        logic      load;
        t_addr_sel addr_sel;
        t_nbr      rd_nbr;
        logic      fin_re;
        logic      base_re;
        logic      fin_we;
        logic      base_we;
        logic      wr_restore;
        logic      cap_en;
        t_nbr      cap_nbr;
        logic      mul_en;
        t_mul_sel  mul_sel;
        logic      ux_en;
        logic      uz_en;
        logic      tri_en;
        logic      diff_en;
        logic      acc_en;
        logic      acc_add;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic            cell_on;
        logic            off_grid;
    } t_dp_stat;

endpackage

/* hw/rtl/heightfield_triangle_sampler.sv */
// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_ready      i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_ready    o_out_data (t_out_item)
// cfg       input      i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
// One item is worked at a time; the steps are set by the one-port grid memory reads and the
// shared multiplier, and an off-grid query skips the neighbour reads of an on-grid one.
// The result register lets the next item be taken while a result waits for transfer.
// Reset is synchronous and active low; the grids are not cleared.
module heightfield_triangle_sampler
    import hts_pkg::*;
#(
    parameter int MAX_SIDE         = DEF_MAX_SIDE,
    parameter int HEIGHT_FRAC_BITS = DEF_HEIGHT_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    hts_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    hts_datapath #(
        .MAX_SIDE         (MAX_SIDE),
        .HEIGHT_FRAC_BITS (HEIGHT_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (o_out_data)
    );

endmodule

/* hw/rtl/hts_datapath.sv */
module hts_datapath
    import hts_pkg::*;
#(
    parameter int MAX_SIDE         = DEF_MAX_SIDE,
    parameter int HEIGHT_FRAC_BITS = DEF_HEIGHT_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_in_item             i_in_data,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output t_out_item            o_out_data
);

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 2 ** AW;
    localparam int CFRAC = HEIGHT_FRAC_BITS + 16;
    localparam int MA_W  = H_W + 1;
    localparam int MB_W  = (INV_W + 1 > CFRAC + 2) ? INV_W + 1 : CFRAC + 2;
    localparam int P_W   = MA_W + MB_W;
    localparam int U_W   = P_W + 1;
    localparam int R_W   = H_W + 3;

    logic [SIZE_W-1:0] r_size_x;
    logic [SIZE_W-1:0] r_size_z;
    logic [INV_W-1:0]  r_inv;
    logic [H_W-1:0]    r_outside;

    t_in_item r_in;

    logic [H_W-1:0] r_fin_mem  [0:DEPTH-1];
    logic [H_W-1:0] r_base_mem [0:DEPTH-1];
    logic [H_W-1:0] r_fin_q;
    logic [H_W-1:0] r_base_q;

    logic signed [P_W-1:0]  r_prod;
    logic signed [U_W-1:0]  r_ux;
    logic signed [U_W-1:0]  r_uz;
    logic                   r_upper;
    logic [CFRAC:0]         r_wa;
    logic [CFRAC:0]         r_wb;
    logic signed [H_W-1:0]  r_h00;
    logic signed [H_W-1:0]  r_h10;
    logic signed [H_W-1:0]  r_h01;
    logic signed [H_W-1:0]  r_h11;
    logic signed [MA_W-1:0] r_da;
    logic signed [MA_W-1:0] r_db;
    logic signed [P_W-1:0]  r_acc;
    t_out_item              r_out;

    logic [SW-1:0]          eff_x;
    logic [SW-1:0]          eff_z;
    logic [CW-1:0]          last_x;
    logic [CW-1:0]          last_z;
    logic                   x_on;
    logic                   z_on;
    logic [CW-1:0]          cx_cl;
    logic [CW-1:0]          cz_cl;
    logic signed [U_W-1:0]  off_x;
    logic signed [U_W-1:0]  off_z;
    logic signed [U_W-1:0]  lim_x;
    logic signed [U_W-1:0]  lim_z;
    logic                   off_grid;
    logic [CW-1:0]          ix;
    logic [CW-1:0]          iz;
    logic [CW-1:0]          ix1;
    logic [CW-1:0]          iz1;
    logic [CFRAC-1:0]       fx;
    logic [CFRAC-1:0]       fz;
    logic [CFRAC:0]         one;
    logic [AW-1:0]          nbr_addr;
    logic [AW-1:0]          mem_addr;
    logic [H_W-1:0]         fin_wdata;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [P_W-1:0]  mul_p;
    logic signed [P_W-1:0]  acc_sh;
    logic signed [R_W-1:0]  h_sum;
    logic signed [H_W-1:0]  h_base;
    logic signed [H_W-1:0]  h_sat;
    t_out_item              res;

    function automatic logic [SW-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SW-1:0] e;
        if (s < MIN_SIZE) begin
            e = SW'(MIN_SIZE);
        end else if (32'(s) > 32'(MAX_SIDE)) begin
            e = SW'(MAX_SIDE);
        end else begin
            e = SW'(s);
        end
        return e;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x  <= RST_SIZE;
            r_size_z  <= RST_SIZE;
            r_inv     <= RST_INV;
            r_outside <= RST_OUTSIDE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SIZE_X:  r_size_x  <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z:  r_size_z  <= i_cfg_data[SIZE_W-1:0];
                CFG_INV:     r_inv     <= i_cfg_data[INV_W-1:0];
                CFG_OUTSIDE: r_outside <= i_cfg_data[H_W-1:0];
            endcase
        end
    end

    always_comb begin
        eff_x  = eff_size(r_size_x);
        eff_z  = eff_size(r_size_z);
        last_x = CW'(eff_x - SW'(1));
        last_z = CW'(eff_z - SW'(1));
        x_on   = !r_in.cell_x[CELL_W-1] && (32'(r_in.cell_x[CELL_W-2:0]) < 32'(eff_x));
        z_on   = !r_in.cell_z[CELL_W-1] && (32'(r_in.cell_z[CELL_W-2:0]) < 32'(eff_z));
        if (r_in.cell_x[CELL_W-1]) begin
            cx_cl = '0;
        end else if (x_on) begin
            cx_cl = r_in.cell_x[CW-1:0];
        end else begin
            cx_cl = last_x;
        end
        if (r_in.cell_z[CELL_W-1]) begin
            cz_cl = '0;
        end else if (z_on) begin
            cz_cl = r_in.cell_z[CW-1:0];
        end else begin
            cz_cl = last_z;
        end
    end

    always_comb begin
        off_x    = U_W'(last_x) <<< (CFRAC - 1);
        off_z    = U_W'(last_z) <<< (CFRAC - 1);
        lim_x    = U_W'(last_x) <<< CFRAC;
        lim_z    = U_W'(last_z) <<< CFRAC;
        off_grid = r_ux[U_W-1] || r_uz[U_W-1] || (r_ux > lim_x) || (r_uz > lim_z);
        ix       = r_ux[CFRAC +: CW];
        iz       = r_uz[CFRAC +: CW];
        ix1      = (ix == last_x) ? ix : ix + CW'(1);
        iz1      = (iz == last_z) ? iz : iz + CW'(1);
        fx       = r_ux[CFRAC-1:0];
        fz       = r_uz[CFRAC-1:0];
        one      = {1'b1, {CFRAC{1'b0}}};
    end

    always_comb begin
        case (i_cmd.rd_nbr)
            NBR_00: nbr_addr = {iz, ix};
            NBR_10: nbr_addr = {iz, ix1};
            NBR_01: nbr_addr = {iz1, ix};
            NBR_11: nbr_addr = {iz1, ix1};
            default: nbr_addr = {iz, ix};
        endcase
        mem_addr  = (i_cmd.addr_sel == ADDR_NBR) ? nbr_addr : {cz_cl, cx_cl};
        fin_wdata = i_cmd.wr_restore ? r_base_q : r_in.height_value;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_we) begin
            r_fin_mem[mem_addr] <= fin_wdata;
        end
        if (i_cmd.fin_re) begin
            r_fin_q <= r_fin_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.base_we) begin
            r_base_mem[mem_addr] <= r_in.height_value;
        end
        if (i_cmd.base_re) begin
            r_base_q <= r_base_mem[mem_addr];
        end
    end

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_PX: begin
                mul_a = MA_W'(r_in.pos_x);
                mul_b = MB_W'(r_inv);
            end
            MUL_PZ: begin
                mul_a = MA_W'(r_in.pos_z);
                mul_b = MB_W'(r_inv);
            end
            MUL_TA: begin
                mul_a = r_da;
                mul_b = MB_W'(r_wa);
            end
            MUL_TB: begin
                mul_a = r_db;
                mul_b = MB_W'(r_wb);
            end
            default: begin
                mul_a = r_da;
                mul_b = MB_W'(r_wa);
            end
        endcase
        mul_p = P_W'(mul_a) * P_W'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_cmd.ux_en) begin
            r_ux <= U_W'(r_prod) + off_x;
        end
        if (i_cmd.uz_en) begin
            r_uz <= U_W'(r_prod) + off_z;
        end
        if (i_cmd.tri_en) begin
            r_upper <= ({1'b0, fx} + {1'b0, fz}) > one;
            if (({1'b0, fx} + {1'b0, fz}) > one) begin
                r_wa <= one - {1'b0, fx};
                r_wb <= one - {1'b0, fz};
            end else begin
                r_wa <= {1'b0, fx};
                r_wb <= {1'b0, fz};
            end
        end
        if (i_cmd.cap_en) begin
            case (i_cmd.cap_nbr)
                NBR_00: r_h00 <= r_fin_q;
                NBR_10: r_h10 <= r_fin_q;
                NBR_01: r_h01 <= r_fin_q;
                NBR_11: r_h11 <= r_fin_q;
                default: r_h00 <= r_fin_q;
            endcase
        end
        if (i_cmd.diff_en) begin
            if (r_upper) begin
                r_da <= MA_W'(r_h01) - MA_W'(r_h11);
                r_db <= MA_W'(r_h10) - MA_W'(r_h11);
            end else begin
                r_da <= MA_W'(r_h10) - MA_W'(r_h00);
                r_db <= MA_W'(r_h01) - MA_W'(r_h00);
            end
        end
        if (i_cmd.acc_en) begin
            r_acc <= i_cmd.acc_add ? r_acc + r_prod : r_prod;
        end
        if (i_cmd.out_load) begin
            r_out <= res;
        end
    end

    always_comb begin
        acc_sh = r_acc >>> CFRAC;
        h_base = r_upper ? r_h11 : r_h00;
        h_sum  = R_W'(acc_sh) + R_W'(h_base);
        if (h_sum > R_W'(H_MAX)) begin
            h_sat = H_MAX;
        end else if (h_sum < R_W'(H_MIN)) begin
            h_sat = H_MIN;
        end else begin
            h_sat = h_sum[H_W-1:0];
        end
    end

    always_comb begin
        case (r_in.opcode) inside
            OP_WR_FIN, OP_WR_BASE, OP_RESTORE: begin
                res.height_out = '0;
                res.inside_res = x_on && z_on;
            end
            OP_RD_FIN: begin
                res.height_out = r_fin_q;
                res.inside_res = x_on && z_on;
            end
            OP_RD_BASE: begin
                res.height_out = r_base_q;
                res.inside_res = x_on && z_on;
            end
            OP_QUERY: begin
                res.height_out = off_grid ? r_outside : h_sat;
                res.inside_res = !off_grid;
            end
            default: begin
                res.height_out = '0;
                res.inside_res = 1'b0;
            end
        endcase
    end

    assign o_stat.opcode   = r_in.opcode;
    assign o_stat.cell_on  = x_on && z_on;
    assign o_stat.off_grid = off_grid;
    assign o_out_data      = r_out;

endmodule

/* hw/rtl/hts_controller.sv */
`include "heightfield_triangle_sampler_assert.svh"

module hts_controller
    import hts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.opcode) inside
                    OP_RESTORE: n_state = S_RESTORE;
                    OP_QUERY:   n_state = S_MUL_Z;
                    default:    n_state = S_FINISH;
                endcase
            end
            S_RESTORE: n_state = S_FINISH;
            S_MUL_Z:   n_state = S_ADD_Z;
            S_ADD_Z:   n_state = S_CHECK;
            S_CHECK:   n_state = i_stat.off_grid ? S_FINISH : S_RD00;
            S_RD00:    n_state = S_RD10;
            S_RD10:    n_state = S_RD01;
            S_RD01:    n_state = S_RD11;
            S_RD11:    n_state = S_CAP11;
            S_CAP11:   n_state = S_DIFF;
            S_DIFF:    n_state = S_PROD_A;
            S_PROD_A:  n_state = S_PROD_B;
            S_PROD_B:  n_state = S_SUM;
            S_SUM:     n_state = S_FINISH;
            S_FINISH: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.addr_sel = ADDR_CELL;
                unique case (i_stat.opcode) inside
                    OP_WR_FIN:  o_cmd.fin_we  = i_stat.cell_on;
                    OP_WR_BASE: o_cmd.base_we = i_stat.cell_on;
                    OP_RESTORE, OP_RD_BASE: o_cmd.base_re = 1'b1;
                    OP_RD_FIN:  o_cmd.fin_re  = 1'b1;
                    OP_QUERY: begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = MUL_PX;
                    end
                    default: o_cmd.load = 1'b0;
                endcase
            end
            S_RESTORE: begin
                o_cmd.addr_sel   = ADDR_CELL;
                o_cmd.wr_restore = 1'b1;
                o_cmd.fin_we     = i_stat.cell_on;
            end
            S_MUL_Z: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_PZ;
                o_cmd.ux_en   = 1'b1;
            end
            S_ADD_Z: begin
                o_cmd.uz_en = 1'b1;
            end
            S_CHECK: begin
                o_cmd.tri_en = 1'b1;
            end
            S_RD00: begin
                o_cmd.addr_sel = ADDR_NBR;
                o_cmd.rd_nbr   = NBR_00;
                o_cmd.fin_re   = 1'b1;
            end
            S_RD10: begin
                o_cmd.addr_sel = ADDR_NBR;
                o_cmd.rd_nbr   = NBR_10;
                o_cmd.fin_re   = 1'b1;
                o_cmd.cap_en   = 1'b1;
                o_cmd.cap_nbr  = NBR_00;
            end
            S_RD01: begin
                o_cmd.addr_sel = ADDR_NBR;
                o_cmd.rd_nbr   = NBR_01;
                o_cmd.fin_re   = 1'b1;
                o_cmd.cap_en   = 1'b1;
                o_cmd.cap_nbr  = NBR_10;
            end
            S_RD11: begin
                o_cmd.addr_sel = ADDR_NBR;
                o_cmd.rd_nbr   = NBR_11;
                o_cmd.fin_re   = 1'b1;
                o_cmd.cap_en   = 1'b1;
                o_cmd.cap_nbr  = NBR_01;
            end
            S_CAP11: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_nbr = NBR_11;
            end
            S_DIFF: begin
                o_cmd.diff_en = 1'b1;
            end
            S_PROD_A: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_TA;
            end
            S_PROD_B: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_TB;
                o_cmd.acc_en  = 1'b1;
                o_cmd.acc_add = 1'b0;
            end
            S_SUM: begin
                o_cmd.acc_en  = 1'b1;
                o_cmd.acc_add = 1'b1;
            end
            S_FINISH: begin
                o_cmd.out_load = slot_free;
            end
            default: o_cmd.load = 1'b0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `HTS_ASSERT_NOW(a_out_no_overwrite, o_cmd.out_load, !r_out_valid || i_out_ready, "result register overwritten before transfer")
    `HTS_ASSERT_NOW(a_grid_write_on_grid, o_cmd.fin_we || o_cmd.base_we, i_stat.cell_on && !(o_cmd.fin_we && o_cmd.base_we), "grid write off the grid or to both grids")
    `HTS_ASSERT_NEXT(a_off_grid_skips_reads, r_state == S_CHECK && i_stat.off_grid, r_state == S_FINISH, "off-grid query did not go straight to the result")
    `HTS_ASSERT_NEXT(a_accept_closes_input, i_in_valid && o_in_ready, r_state == S_DECODE && !o_in_ready, "input still open after a transfer")

endmodule
